FILE: sv/eshm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eshm_pkg
// Shared types and constants for the string hash block.
// ----------------------------------------------------------------------------
package eshm_pkg;

  localparam int CodeW   = 16;
  localparam int HashW   = 28;
  localparam int SizeW   = 32;
  localparam int DivSteps = HashW;
  localparam int CntW    = $clog2(DivSteps);

  localparam logic [SizeW-1:0] TableSizeReset = 32'd1024;
  localparam logic [CntW-1:0]  LastStep       = CntW'(DivSteps - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  typedef struct packed {
    logic fold;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_term;
  } status_t;

endpackage

FILE: sv/eshm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eshm_datapath
// Hash fold register, table size register, bit-serial remainder unit and
// output payload registers.
// ----------------------------------------------------------------------------
module eshm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [eshm_pkg::SizeW-1:0]    cfg_wr_data,
  input  logic [eshm_pkg::CodeW-1:0]    in_code_unit,
  input  eshm_pkg::cmd_t                cmd,
  output eshm_pkg::status_t             status,
  output logic [eshm_pkg::SizeW-1:0]    out_bucket,
  output logic [eshm_pkg::HashW-1:0]    out_raw_hash
);

  logic [eshm_pkg::SizeW-1:0] table_size_r;
  logic [eshm_pkg::HashW-1:0] hash_r, hash_nxt;
  logic [eshm_pkg::HashW-1:0] dividend_r;
  logic [eshm_pkg::HashW-1:0] raw_r;
  logic [eshm_pkg::SizeW-1:0] divisor_r;
  logic [eshm_pkg::SizeW-1:0] rem_r, rem_nxt;
  logic [eshm_pkg::SizeW-1:0] bucket_r;
  logic [eshm_pkg::HashW-1:0] raw_out_r;

  logic [eshm_pkg::SizeW-1:0] sum;
  logic [eshm_pkg::SizeW:0]   rem_shift;
  logic [eshm_pkg::SizeW:0]   rem_diff;

  assign status.is_term = (in_code_unit == '0);

  // The top nibble of the sum lands on bits 7:4 after the 24-bit shift.
  always_comb begin
    sum      = {hash_r, 4'b0000} + eshm_pkg::SizeW'(in_code_unit);
    hash_nxt = sum[eshm_pkg::HashW-1:0]
             ^ {{(eshm_pkg::HashW-8){1'b0}}, sum[eshm_pkg::SizeW-1:eshm_pkg::HashW], 4'b0000};
  end

  always_comb begin
    rem_shift = {rem_r, dividend_r[eshm_pkg::HashW-1]};
    rem_diff  = rem_shift - {1'b0, divisor_r};
    if (rem_shift >= {1'b0, divisor_r}) begin
      rem_nxt = rem_diff[eshm_pkg::SizeW-1:0];
    end else begin
      rem_nxt = rem_shift[eshm_pkg::SizeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= eshm_pkg::TableSizeReset;
      hash_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        table_size_r <= cfg_wr_data;
      end
      if (cmd.fold) begin
        hash_r <= hash_nxt;
      end else if (cmd.start) begin
        hash_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dividend_r <= hash_r;
      raw_r      <= hash_r;
      divisor_r  <= table_size_r;
      rem_r      <= '0;
    end else if (cmd.step) begin
      dividend_r <= {dividend_r[eshm_pkg::HashW-2:0], 1'b0};
      rem_r      <= rem_nxt;
    end
    if (cmd.load_out) begin
      bucket_r  <= rem_r;
      raw_out_r <= raw_r;
    end
  end

  assign out_bucket   = bucket_r;
  assign out_raw_hash = raw_out_r;

endmodule

FILE: sv/eshm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eshm_ctrl
// Controller for input acceptance, the remainder step count and the output
// register handshake.
// ----------------------------------------------------------------------------
module eshm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  eshm_pkg::status_t  status,
  output eshm_pkg::cmd_t     cmd
);

  eshm_pkg::state_t          state_r, state_nxt;
  logic [eshm_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      acc;
  logic                      out_free;

  assign in_ready  = (state_r == eshm_pkg::S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.fold     = 1'b0;
    cmd.start    = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      eshm_pkg::S_IDLE: begin
        if (acc) begin
          if (status.is_term) begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = eshm_pkg::S_DIV;
          end else begin
            cmd.fold = 1'b1;
          end
        end
      end
      eshm_pkg::S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == eshm_pkg::LastStep) begin
          state_nxt = eshm_pkg::S_HOLD;
        end
      end
      eshm_pkg::S_HOLD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = eshm_pkg::S_IDLE;
        end
      end
      default: state_nxt = eshm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eshm_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == eshm_pkg::S_DIV) && (cnt_r == '0))
    else $error("terminator transfer did not start the remainder unit");

  a_div_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == eshm_pkg::S_DIV) && (cnt_r != eshm_pkg::LastStep)
      |=> (state_r == eshm_pkg::S_DIV) && (cnt_r == $past(cnt_r) + 1'b1))
    else $error("remainder step count broke off early");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == eshm_pkg::S_DIV) && (cnt_r == eshm_pkg::LastStep)
      |=> (state_r == eshm_pkg::S_HOLD))
    else $error("remainder unit did not finish after the last step");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

endmodule

FILE: sv/elf_string_hash_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_string_hash_mod
// Folds 16-bit character codes into a 28-bit PJW-style hash and, on a zero
// code, returns the hash and the hash modulo the configured table size.
//
//   Channel  Direction  Signals
//   in       sink       in_valid, in_ready, in_code_unit
//   out      source     out_valid, out_ready, out_bucket, out_raw_hash
//   cfg      sink       cfg_wr_en, cfg_wr_data (table size)
//
// A non-zero code is folded on acceptance, so characters transfer back to back.
// A terminator is accepted and then passes through the bit-serial remainder
// unit (one quotient bit per cycle), then waits for a free output register.
// in_ready is low while the remainder unit runs and until its result is loaded.
// A result waiting in the output register does not block further characters.
// Reset is synchronous and active low; the table size resets to 1024.
// ----------------------------------------------------------------------------
module elf_string_hash_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [eshm_pkg::SizeW-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [eshm_pkg::CodeW-1:0]    in_code_unit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [eshm_pkg::SizeW-1:0]    out_bucket,
  output logic [eshm_pkg::HashW-1:0]    out_raw_hash
);

  eshm_pkg::cmd_t    cmd;
  eshm_pkg::status_t status;

  eshm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  eshm_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_code_unit (in_code_unit),
    .cmd          (cmd),
    .status       (status),
    .out_bucket   (out_bucket),
    .out_raw_hash (out_raw_hash)
  );

endmodule

FILE: dv/elf_string_hash_mod_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elf_string_hash_mod_tb
// Self-checking bench for the string hash block. Character codes are fed as
// strings ending in a zero code. A local model folds each code into its own
// hash and queues the bucket and raw hash that each terminator must return.
// Returned results are checked in order. The table size is rewritten between
// phases, including the extremes and the out-of-range zero. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module elf_string_hash_mod_tb;

  localparam int CodeW = eshm_pkg::CodeW;
  localparam int HashW = eshm_pkg::HashW;
  localparam int SizeW = eshm_pkg::SizeW;

  localparam logic [CodeW-1:0] TERMINATOR  = '0;
  localparam int               SETTLE_CYC  = 40;
  localparam int               CYCLE_LIMIT = 500_000;

  typedef struct packed {
    logic [SizeW-1:0] bucket;
    logic [HashW-1:0] raw_hash;
  } hash_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [SizeW-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  logic [CodeW-1:0] in_code_unit;
  logic             out_valid;
  logic             out_ready;
  logic [SizeW-1:0] out_bucket;
  logic [HashW-1:0] out_raw_hash;

  hash_result_t     expected_hashes[$];
  logic [HashW-1:0] hash_state;
  logic [SizeW-1:0] table_size_model;
  int               error_count;
  int               cycle_count;
  int               in_gap_pct;
  int               out_stall_pct;
  int               stall_left;

  elf_string_hash_mod u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_code_unit(in_code_unit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_bucket  (out_bucket),
    .out_raw_hash(out_raw_hash)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("elf_string_hash_mod_tb: errors");
      $finish;
    end
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < out_stall_pct) begin
      stall_left <= pick_gap(100) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [HashW-1:0] fold_code(logic [HashW-1:0] h, logic [CodeW-1:0] c);
    logic [31:0] sum;
    sum = {h, 4'b0000} + 32'(c);
    if (sum[31:28] != 4'd0) sum[7:4] = sum[7:4] ^ sum[31:28];
    return sum[HashW-1:0];
  endfunction

  function automatic void predict_code(logic [CodeW-1:0] code);
    hash_result_t res;
    if (code != TERMINATOR) begin
      hash_state = fold_code(hash_state, code);
    end else begin
      res.raw_hash = hash_state;
      res.bucket   = (table_size_model == '0) ? SizeW'(hash_state)
                                               : SizeW'(hash_state) % table_size_model;
      expected_hashes.push_back(res);
      hash_state = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t: result with none expected: bucket %h raw_hash %h",
                 $time, out_bucket, out_raw_hash);
        error_count++;
      end else begin
        if (out_bucket !== expected_hashes[0].bucket) begin
          $display("%0t: bucket expected %h actual %h",
                   $time, expected_hashes[0].bucket, out_bucket);
          error_count++;
        end
        if (out_raw_hash !== expected_hashes[0].raw_hash) begin
          $display("%0t: raw_hash expected %h actual %h",
                   $time, expected_hashes[0].raw_hash, out_raw_hash);
          error_count++;
        end
        void'(expected_hashes.pop_front());
      end
    end
  end

  task automatic send_code(input logic [CodeW-1:0] code);
    int gap;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_unit <= code;
    predict_code(code);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_table_size(input logic [SizeW-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    table_size_model = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CodeW-1:0] random_code();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return CodeW'($urandom_range(65535, 1));
    if (pick < 8) return CodeW'($urandom_range(127, 1));
    return {8'hFF, 8'($urandom)};
  endfunction

  task automatic send_string(input int len);
    for (int i = 0; i < len; i++) send_code(random_code());
    send_code(TERMINATOR);
  endtask

  // Reset value of the table size, empty strings and strings long enough
  // to push bits into the top nibble.
  task automatic test_directed();
    send_code(TERMINATOR);
    send_code(16'hFFFF);
    send_code(TERMINATOR);
    send_code(16'h0001);
    send_code(TERMINATOR);
    send_code(TERMINATOR);
    for (int i = 0; i < 10; i++) send_code(16'hFFFF);
    send_code(TERMINATOR);
    for (int i = 0; i < 8; i++) send_code(16'h8000);
    send_code(TERMINATOR);
  endtask

  task automatic test_random_strings(input int n_items);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(19);
      if (pick == 0) len = 0;
      else if (pick < 4) len = $urandom_range(30, 11);
      else len = $urandom_range(10, 1);
      send_string(len);
      sent += len + 1;
    end
  endtask

  task automatic test_table_sizes();
    set_table_size(32'd1);
    test_random_strings(100);
    set_table_size(32'hFFFF_FFFF);
    test_random_strings(100);
    set_table_size('0);
    test_random_strings(80);
    set_table_size(SizeW'($urandom_range(64, 2)));
    test_random_strings(100);
    set_table_size($urandom());
    test_random_strings(80);
    set_table_size(SizeW'($urandom_range(32'h1000_0000, 32'h0010_0000)));
    test_random_strings(80);
  endtask

  task automatic test_idle_mix();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    set_table_size(SizeW'($urandom_range(1000, 3)));
    test_random_strings(100);
    in_gap_pct    = 60;
    out_stall_pct = 60;
    set_table_size(eshm_pkg::TableSizeReset);
    test_random_strings(100);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_code_unit     = '0;
    out_ready        = 1'b0;
    stall_left       = 0;
    error_count      = 0;
    cycle_count      = 0;
    in_gap_pct       = 25;
    out_stall_pct    = 25;
    hash_state       = '0;
    table_size_model = eshm_pkg::TableSizeReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_sizes();
    test_idle_mix();

    wait_drained();
    if (error_count == 0) begin
      $display("elf_string_hash_mod_tb: clean");
    end else begin
      $display("elf_string_hash_mod_tb: errors");
    end
    $finish;
  end

endmodule

FILE: elf_string_hash_mod.f
sv/eshm_pkg.sv
sv/eshm_datapath.sv
sv/eshm_ctrl.sv
sv/elf_string_hash_mod.sv
dv/elf_string_hash_mod_tb.sv
